@@ sv/kalman_angle_bias_filter_assert.svh @@
// Assertion macros for the angle/bias filter.
// Used by the top level only; no other dependencies.
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define KABF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define KABF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KABF_ASSERT_NOW(lbl, ante, cons, msg)
`define KABF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/kabf_pkg.sv @@
// Shared constants, types and the update microprogram for the angle/bias filter.
// No dependencies.
package kabf_pkg;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int ANGLE_W    = 32;
   localparam int DT_W       = 16;
   localparam int STEP_W     = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_NOISE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_NOISE  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_EN     = 8'd3;

   localparam logic [31:0] ANGLE_NOISE_RST = 32'd4294967;
   localparam logic [31:0] BIAS_NOISE_RST  = 32'd12884902;
   localparam logic [31:0] MEAS_NOISE_RST  = 32'd128849019;

   // micro-op codes
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL16 = 3'd2;
   localparam logic [2:0] OP_MUL32 = 3'd3;
   localparam logic [2:0] OP_DIV   = 3'd4;
   localparam logic [2:0] OP_END   = 3'd5;

   // operand / destination codes
   localparam logic [4:0] R_AE  = 5'd0;
   localparam logic [4:0] R_BE  = 5'd1;
   localparam logic [4:0] R_P00 = 5'd2;
   localparam logic [4:0] R_P01 = 5'd3;
   localparam logic [4:0] R_P10 = 5'd4;
   localparam logic [4:0] R_P11 = 5'd5;
   localparam logic [4:0] R_Z   = 5'd6;
   localparam logic [4:0] R_W   = 5'd7;
   localparam logic [4:0] R_DT  = 5'd8;
   localparam logic [4:0] R_T   = 5'd9;
   localparam logic [4:0] R_U   = 5'd10;
   localparam logic [4:0] R_Y   = 5'd11;
   localparam logic [4:0] R_S   = 5'd12;
   localparam logic [4:0] R_K0  = 5'd13;
   localparam logic [4:0] R_K1  = 5'd14;
   localparam logic [4:0] R_AN  = 5'd15;
   localparam logic [4:0] R_BN  = 5'd16;
   localparam logic [4:0] R_MN  = 5'd17;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic [4:0] dst;
   } uop_type;

   typedef struct packed {
      logic start;
      logic sh32;
   } mul_ctl_type;

   function automatic uop_type uop_at(input logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         5'd0:  u = '{OP_SUB,   R_W,   R_BE,  R_Y};
         5'd1:  u = '{OP_MUL16, R_DT,  R_Y,   R_Y};
         5'd2:  u = '{OP_ADD,   R_AE,  R_Y,   R_AE};
         5'd3:  u = '{OP_MUL16, R_DT,  R_P11, R_U};
         5'd4:  u = '{OP_SUB,   R_U,   R_P01, R_T};
         5'd5:  u = '{OP_SUB,   R_T,   R_P10, R_T};
         5'd6:  u = '{OP_ADD,   R_T,   R_AN,  R_T};
         5'd7:  u = '{OP_MUL16, R_DT,  R_T,   R_T};
         5'd8:  u = '{OP_ADD,   R_P00, R_T,   R_P00};
         5'd9:  u = '{OP_SUB,   R_P01, R_U,   R_P01};
         5'd10: u = '{OP_SUB,   R_P10, R_U,   R_P10};
         5'd11: u = '{OP_MUL16, R_BN,  R_DT,  R_T};
         5'd12: u = '{OP_ADD,   R_P11, R_T,   R_P11};
         5'd13: u = '{OP_ADD,   R_P00, R_MN,  R_S};
         5'd14: u = '{OP_DIV,   R_P00, R_P10, R_K0};
         5'd15: u = '{OP_SUB,   R_Z,   R_AE,  R_Y};
         5'd16: u = '{OP_MUL32, R_K0,  R_Y,   R_T};
         5'd17: u = '{OP_ADD,   R_AE,  R_T,   R_AE};
         5'd18: u = '{OP_MUL32, R_K1,  R_Y,   R_T};
         5'd19: u = '{OP_ADD,   R_BE,  R_T,   R_BE};
         // bias row first so both rows see the pre-update angle row
         5'd20: u = '{OP_MUL32, R_K1,  R_P00, R_T};
         5'd21: u = '{OP_SUB,   R_P10, R_T,   R_P10};
         5'd22: u = '{OP_MUL32, R_K1,  R_P01, R_T};
         5'd23: u = '{OP_SUB,   R_P11, R_T,   R_P11};
         5'd24: u = '{OP_MUL32, R_K0,  R_P00, R_T};
         5'd25: u = '{OP_SUB,   R_P00, R_T,   R_P00};
         5'd26: u = '{OP_MUL32, R_K0,  R_P01, R_T};
         5'd27: u = '{OP_SUB,   R_P01, R_T,   R_P01};
         default: u = '{OP_END, R_AE, R_AE, R_AE};
      endcase
      return u;
   endfunction

endpackage

@@ sv/kabf_intf.sv @@
// Channel interfaces for the angle/bias filter: item in, result out, register write.
// Depends on kabf_pkg.
interface kabf_req_if import kabf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] measured_angle;
   logic signed [ANGLE_W-1:0] angular_rate;
   logic [DT_W-1:0]           time_step;
   modport source (output valid, measured_angle, angular_rate, time_step, input ready);
   modport sink   (input valid, measured_angle, angular_rate, time_step, output ready);
endinterface

interface kabf_rsp_if import kabf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] filtered_angle;
   logic signed [ANGLE_W-1:0] gyro_bias;
   logic                      guard_taken;
   logic                      gain_fault;
   modport source (output valid, filtered_angle, gyro_bias, guard_taken, gain_fault,
                   input ready);
   modport sink   (input valid, filtered_angle, gyro_bias, guard_taken, gain_fault,
                   output ready);
endinterface

interface kabf_csr_if import kabf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ sv/kabf_mul.sv @@
// Iterative saturating multiplier: four 32x32 partial products, round, shift, clamp.
// Depends on kabf_pkg.
module kabf_mul import kabf_pkg::*; #(
   parameter int IW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mul_ctl_type          ctl,
   input  logic signed [IW-1:0] a,
   input  logic signed [IW-1:0] b,
   output logic                 done,
   output logic signed [IW-1:0] y
);
   localparam logic [127:0]   POS_LIM = (128'd1 << (IW-1)) - 128'd1;
   localparam logic [127:0]   NEG_LIM = 128'd1 << (IW-1);
   localparam logic [IW-1:0]  VMAX    = {1'b0, {(IW-1){1'b1}}};
   localparam logic [IW-1:0]  VMIN    = {1'b1, {(IW-1){1'b0}}};

   logic [63:0]  ma_ff, mb_ff, pp_ff;
   logic [127:0] acc_ff, addend, shifted;
   logic         neg_ff, sh32_ff, busy_ff;
   logic [2:0]   cnt_ff;
   logic [31:0]  mx, my;
   logic [63:0]  pp_in;

   function automatic logic [63:0] magn(input logic signed [IW-1:0] v);
      logic [63:0] e;
      e = 64'(v);
      return v[IW-1] ? (64'd0 - e) : e;
   endfunction

   always_comb begin
      mx    = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      my    = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp_in = mx * my;
      case (cnt_ff)
         3'd1:    addend = {64'd0, pp_ff};
         3'd2,
         3'd3:    addend = {32'd0, pp_ff, 32'd0};
         3'd4:    addend = {pp_ff, 64'd0};
         3'd5:    addend = sh32_ff ? (128'd1 << 31) : (128'd1 << 15);
         default: addend = 128'd0;
      endcase
      shifted = sh32_ff ? (acc_ff >> 32) : (acc_ff >> 16);
      if (neg_ff) begin
         y = (shifted > NEG_LIM) ? VMIN : (IW'(0) - shifted[IW-1:0]);
      end else begin
         y = (shifted > POS_LIM) ? VMAX : shifted[IW-1:0];
      end
   end

   assign done = busy_ff && (cnt_ff == 3'd6);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd6) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         ma_ff   <= magn(a);
         mb_ff   <= magn(b);
         neg_ff  <= a[IW-1] ^ b[IW-1];
         sh32_ff <= ctl.sh32;
         acc_ff  <= 128'd0;
      end else if (busy_ff) begin
         pp_ff  <= pp_in;
         acc_ff <= acc_ff + addend;
      end
   end
endmodule

@@ sv/kabf_div.sv @@
// Bit-serial dual-lane divider: (n << 32) / d for two numerators sharing one divisor.
// Depends on kabf_pkg.
module kabf_div import kabf_pkg::*; #(
   parameter int IW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [IW-1:0] n0,
   input  logic signed [IW-1:0] n1,
   input  logic signed [IW-1:0] d,
   output logic                 done,
   output logic signed [IW-1:0] q0,
   output logic signed [IW-1:0] q1
);
   localparam logic [63:0]   POS_LIM = (64'd1 << (IW-1)) - 64'd1;
   localparam logic [IW-1:0] VMAX    = {1'b0, {(IW-1){1'b1}}};
   localparam logic [IW-1:0] VMIN    = {1'b1, {(IW-1){1'b0}}};
   localparam logic [6:0]    LAST    = 7'd96;

   logic [63:0] ud_ff;
   logic [63:0] num_ff [2];
   logic [63:0] rem_ff [2];
   logic [63:0] quo_ff [2];
   logic        ovf_ff [2];
   logic        neg_ff [2];
   logic [63:0] rem_in [2];
   logic        ge     [2];
   logic [64:0] rr     [2];
   logic [6:0]  cnt_ff;
   logic        busy_ff;

   function automatic logic [63:0] magn(input logic signed [IW-1:0] v);
      logic [63:0] e;
      e = 64'(v);
      return v[IW-1] ? (64'd0 - e) : e;
   endfunction

   function automatic logic [IW-1:0] from_mag(input logic [63:0] m, input logic ovf,
                                              input logic neg);
      logic [IW-1:0] r;
      if (neg) begin
         r = (ovf || m > POS_LIM + 64'd1) ? VMIN : (IW'(0) - m[IW-1:0]);
      end else begin
         r = (ovf || m > POS_LIM) ? VMAX : m[IW-1:0];
      end
      return r;
   endfunction

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         rr[k]     = {rem_ff[k], num_ff[k][63]};
         ge[k]     = rr[k] >= {1'b0, ud_ff};
         rem_in[k] = ge[k] ? 64'(rr[k] - {1'b0, ud_ff}) : rr[k][63:0];
      end
   end

   assign done = busy_ff && (cnt_ff == LAST);
   assign q0   = from_mag(quo_ff[0], ovf_ff[0], neg_ff[0]);
   assign q1   = from_mag(quo_ff[1], ovf_ff[1], neg_ff[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 7'd0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 7'd1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ud_ff     <= magn(d);
         num_ff[0] <= magn(n0);
         num_ff[1] <= magn(n1);
         neg_ff[0] <= n0[IW-1] ^ d[IW-1];
         neg_ff[1] <= n1[IW-1] ^ d[IW-1];
         for (int k = 0; k < 2; k++) begin
            rem_ff[k] <= 64'd0;
            quo_ff[k] <= 64'd0;
            ovf_ff[k] <= 1'b0;
         end
      end else if (busy_ff && cnt_ff != LAST) begin
         for (int k = 0; k < 2; k++) begin
            num_ff[k] <= {num_ff[k][62:0], 1'b0};
            rem_ff[k] <= rem_in[k];
            ovf_ff[k] <= ovf_ff[k] | quo_ff[k][63];
            quo_ff[k] <= {quo_ff[k][62:0], ge[k]};
         end
      end
   end
endmodule

@@ sv/kalman_angle_bias_filter.sv @@
// Channel     | dir | words
// req_if      | in  | measured_angle, angular_rate, time_step
// rsp_if      | out | filtered_angle, gyro_bias, guard_taken, gain_fault
// csr_if      | in  | reg_index, wdata (always ready)
// An item runs from accept to accept through: accept, 17 add/sub steps, 10 multiplies
// on the shared 32x32 multiplier, the bit-serial divide, one end step and the result.
// A zero innovation variance skips the divide; a wrap-guard item skips all steps.
// req ready only while idle; the result holds until rsp ready.
// Synchronous reset clears estimates and covariance.
// Top level of the angle/bias filter; depends on kabf_pkg, kabf_intf, kabf_mul, kabf_div.
`include "kalman_angle_bias_filter_assert.svh"
module kalman_angle_bias_filter import kabf_pkg::*; #(
   parameter int INTERNAL_WIDTH = 64
) (
   input logic        clock,
   input logic        reset,
   kabf_req_if.sink   req_if,
   kabf_rsp_if.source rsp_if,
   kabf_csr_if.sink   csr_if
);
   localparam int IW = INTERNAL_WIDTH;
   localparam logic signed [IW-1:0] VMAX   = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] VMIN   = {1'b1, {(IW-1){1'b0}}};
   localparam logic signed [IW-1:0] NINETY = IW'(64'd90 << 32);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff;
   logic [STEP_W-1:0] step_ff;
   logic signed [IW-1:0] ae_ff, be_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [IW-1:0] z_ff, w_ff, dt_ff, t_ff, u_ff, y_ff, s_ff, k0_ff, k1_ff;
   logic [31:0]       an_ff, bn_ff, mn_ff;
   logic              wrap_ff, guard_ff, fault_ff;

   uop_type              uop;
   logic signed [IW-1:0] opa, opb, alu_res, z_in, wb_val;
   logic                 wb_en, guard_hit, accept;
   logic [4:0]           wb_dst;
   mul_ctl_type          mul_ctl;
   logic                 mul_done, div_start, div_done;
   logic signed [IW-1:0] mul_y, div_q0, div_q1;

   function automatic logic signed [IW-1:0] sat_add(input logic signed [IW-1:0] a,
                                                     input logic signed [IW-1:0] b);
      logic signed [IW:0] s;
      s = {a[IW-1], a} + {b[IW-1], b};
      if (s[IW] != s[IW-1]) begin
         return s[IW] ? VMIN : VMAX;
      end
      return s[IW-1:0];
   endfunction

   function automatic logic [31:0] to_port(input logic signed [IW-1:0] x);
      logic [63:0] m, r;
      m = x[IW-1] ? (64'd0 - 64'(x)) : 64'(x);
      r = (m + 64'd32768) >> 16;
      if (x[IW-1]) begin
         return (r > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - r[31:0]);
      end
      return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
   endfunction

   function automatic logic signed [IW-1:0] pick(input logic [4:0] code,
      input logic signed [IW-1:0] ae, be, p00, p01, p10, p11, z, w, dt, t, u, yv, s,
      k0, k1, input logic [31:0] an, bn, mn);
      logic signed [IW-1:0] v;
      case (code)
         R_AE:    v = ae;
         R_BE:    v = be;
         R_P00:   v = p00;
         R_P01:   v = p01;
         R_P10:   v = p10;
         R_P11:   v = p11;
         R_Z:     v = z;
         R_W:     v = w;
         R_DT:    v = dt;
         R_T:     v = t;
         R_U:     v = u;
         R_Y:     v = yv;
         R_S:     v = s;
         R_K0:    v = k0;
         R_K1:    v = k1;
         R_AN:    v = IW'(an);
         R_BN:    v = IW'(bn);
         R_MN:    v = IW'(mn);
         default: v = '0;
      endcase
      return v;
   endfunction

   assign uop = uop_at(step_ff);
   assign opa = pick(uop.src_a, ae_ff, be_ff, p00_ff, p01_ff, p10_ff, p11_ff, z_ff, w_ff,
                     dt_ff, t_ff, u_ff, y_ff, s_ff, k0_ff, k1_ff, an_ff, bn_ff, mn_ff);
   assign opb = pick(uop.src_b, ae_ff, be_ff, p00_ff, p01_ff, p10_ff, p11_ff, z_ff, w_ff,
                     dt_ff, t_ff, u_ff, y_ff, s_ff, k0_ff, k1_ff, an_ff, bn_ff, mn_ff);

   // subtracting the most negative value adds the most positive one
   assign alu_res = sat_add(opa, (uop.op == OP_SUB) ?
                                 ((opb == VMIN) ? VMAX : (IW'(0) - opb)) : opb);

   assign z_in      = IW'(req_if.measured_angle) <<< 16;
   assign guard_hit = wrap_ff && (((z_in < -NINETY) && (ae_ff > NINETY)) ||
                                  ((z_in > NINETY) && (ae_ff < -NINETY)));
   assign accept    = req_if.valid && req_if.ready;

   assign mul_ctl.start = (state_ff == ST_EXEC) &&
                          (uop.op == OP_MUL16 || uop.op == OP_MUL32);
   assign mul_ctl.sh32  = (uop.op == OP_MUL32);
   assign div_start     = (state_ff == ST_EXEC) && (uop.op == OP_DIV) && (s_ff != '0);

   kabf_mul #(.IW(IW)) u_mul (
      .clock(clock), .reset(reset), .ctl(mul_ctl), .a(opa), .b(opb),
      .done(mul_done), .y(mul_y)
   );

   kabf_div #(.IW(IW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .n0(opa), .n1(opb), .d(s_ff),
      .done(div_done), .q0(div_q0), .q1(div_q1)
   );

   always_comb begin
      wb_en  = 1'b0;
      wb_dst = uop.dst;
      wb_val = alu_res;
      if (state_ff == ST_EXEC && (uop.op == OP_ADD || uop.op == OP_SUB)) begin
         wb_en = 1'b1;
      end else if (state_ff == ST_WAIT && mul_done) begin
         wb_en  = 1'b1;
         wb_val = mul_y;
      end
   end

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = (state_ff == ST_OUT);
   assign rsp_if.filtered_angle = to_port(ae_ff);
   assign rsp_if.gyro_bias      = to_port(be_ff);
   assign rsp_if.guard_taken    = guard_ff;
   assign rsp_if.gain_fault     = fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         an_ff   <= ANGLE_NOISE_RST;
         bn_ff   <= BIAS_NOISE_RST;
         mn_ff   <= MEAS_NOISE_RST;
         wrap_ff <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.reg_index)
            CSR_ANGLE_NOISE: an_ff   <= csr_if.wdata;
            CSR_BIAS_NOISE:  bn_ff   <= csr_if.wdata;
            CSR_MEAS_NOISE:  mn_ff   <= csr_if.wdata;
            CSR_WRAP_EN:     wrap_ff <= csr_if.wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ae_ff    <= '0;
         be_ff    <= '0;
         p00_ff   <= '0;
         p01_ff   <= '0;
         p10_ff   <= '0;
         p11_ff   <= '0;
         guard_ff <= 1'b0;
         fault_ff <= 1'b0;
      end else begin
         if (wb_en) begin
            case (wb_dst)
               R_AE:    ae_ff  <= wb_val;
               R_BE:    be_ff  <= wb_val;
               R_P00:   p00_ff <= wb_val;
               R_P01:   p01_ff <= wb_val;
               R_P10:   p10_ff <= wb_val;
               R_P11:   p11_ff <= wb_val;
               R_T:     t_ff   <= wb_val;
               R_U:     u_ff   <= wb_val;
               R_Y:     y_ff   <= wb_val;
               R_S:     s_ff   <= wb_val;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  z_ff     <= z_in;
                  w_ff     <= IW'(req_if.angular_rate) <<< 16;
                  dt_ff    <= IW'(req_if.time_step);
                  fault_ff <= 1'b0;
                  guard_ff <= guard_hit;
                  step_ff  <= '0;
                  if (guard_hit) begin
                     ae_ff    <= z_in;
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_EXEC;
                  end
               end
            end
            ST_EXEC: begin
               case (uop.op)
                  OP_ADD, OP_SUB: step_ff <= step_ff + 1'b1;
                  OP_MUL16, OP_MUL32: state_ff <= ST_WAIT;
                  OP_DIV: begin
                     if (s_ff == '0) begin
                        k0_ff    <= '0;
                        k1_ff    <= '0;
                        fault_ff <= 1'b1;
                        step_ff  <= step_ff + 1'b1;
                     end else begin
                        state_ff <= ST_WAIT;
                     end
                  end
                  default: state_ff <= ST_OUT;
               endcase
            end
            ST_WAIT: begin
               if (mul_done) begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_EXEC;
               end else if (div_done) begin
                  k0_ff    <= div_q0;
                  k1_ff    <= div_q1;
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_EXEC;
               end
            end
            ST_OUT: begin
               if (rsp_if.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `KABF_ASSERT_NOW(a_no_overlap, req_if.ready, !rsp_if.valid, "ready while result pending")
   `KABF_ASSERT_NOW(a_mul_wait, mul_done, state_ff == ST_WAIT, "multiply done outside wait")
   `KABF_ASSERT_NOW(a_flags, rsp_if.valid, !(rsp_if.guard_taken && rsp_if.gain_fault),
                    "guard and fault both set")
   `KABF_ASSERT_NEXT(a_ret_idle, rsp_if.valid && rsp_if.ready, req_if.ready,
                     "not idle after result taken")
endmodule

@@ test/kabf_checker.sv @@
// Checker for the angle/bias filter: predicts each result word from accepted
// request words and register writes, and compares it with the response channel.
// Depends on kabf_pkg and the channel interfaces in kabf_intf.
`timescale 1ns / 1ps
module kabf_checker import kabf_pkg::*; (
   input  logic clock,
   input  logic reset,
   kabf_req_if  req,
   kabf_rsp_if  rsp,
   kabf_csr_if  csr,
   output int   pending,
   output int   mismatches
);

   typedef logic signed [63:0] fx_type;
   localparam fx_type FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam fx_type FX_MIN = 64'sh8000_0000_0000_0000;
   localparam fx_type NINETY_DEG = 64'sd90 <<< 32;

   typedef struct {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] gyro_bias;
      logic               guard_taken;
      logic               gain_fault;
   } filter_out_type;

   fx_type angle_est, bias_est, p00, p01, p10, p11;
   fx_type angle_q, bias_q, meas_q;
   logic wrap_en;
   filter_out_type expected_q[$];

   function automatic logic [63:0] mag(fx_type x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   function automatic fx_type from_mag(logic [63:0] m, logic ovf, logic neg);
      if (neg) return (ovf || m >= 64'h8000_0000_0000_0000) ? FX_MIN : fx_type'(-m);
      return (ovf || m > 64'h7FFF_FFFF_FFFF_FFFF) ? FX_MAX : fx_type'(m);
   endfunction

   function automatic fx_type sat_add(fx_type a, fx_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return FX_MAX;
      if (s < -65'sh0_8000_0000_0000_0000) return FX_MIN;
      return s[63:0];
   endfunction

   function automatic fx_type sat_sub(fx_type a, fx_type b);
      return sat_add(a, (b == FX_MIN) ? FX_MAX : -b);
   endfunction

   // rounded (a*b) >> sh, ties away from zero
   function automatic fx_type mul_rnd(fx_type a, fx_type b, int sh);
      logic [127:0] p;
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      p = p + (128'd1 << (sh - 1));
      p = p >> sh;
      return from_mag(p[63:0], |p[127:64], a[63] != b[63]);
   endfunction

   function automatic fx_type gain_div(fx_type n, fx_type d);
      logic [127:0] q;
      q = ({64'b0, mag(n)} << 32) / {64'b0, mag(d)};
      return from_mag(q[63:0], |q[127:64], n[63] != d[63]);
   endfunction

   function automatic logic signed [31:0] to_port(fx_type x);
      fx_type r;
      r = mul_rnd(x, 64'sd1, 16);
      if (r > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (r < -64'sh8000_0000) return 32'sh8000_0000;
      return r[31:0];
   endfunction

   function automatic filter_out_type filter_update(logic signed [31:0] meas,
                                                     logic signed [31:0] rate_in,
                                                     logic [15:0] dt_in);
      filter_out_type o;
      fx_type z, w, dt, rate, t, s, k0, k1, y, a00, a01;
      z = fx_type'(meas) <<< 16;
      w = fx_type'(rate_in) <<< 16;
      dt = {48'b0, dt_in};
      k0 = 0;
      k1 = 0;
      o.guard_taken = 1'b0;
      o.gain_fault = 1'b0;
      if (wrap_en && ((z < -NINETY_DEG && angle_est > NINETY_DEG) ||
                      (z > NINETY_DEG && angle_est < -NINETY_DEG))) begin
         angle_est = z;
         o.guard_taken = 1'b1;
      end else begin
         rate = sat_sub(w, bias_est);
         angle_est = sat_add(angle_est, mul_rnd(dt, rate, 16));
         t = mul_rnd(dt, p11, 16);
         t = sat_sub(t, p01);
         t = sat_sub(t, p10);
         t = sat_add(t, angle_q);
         p00 = sat_add(p00, mul_rnd(dt, t, 16));
         t = mul_rnd(dt, p11, 16);
         p01 = sat_sub(p01, t);
         p10 = sat_sub(p10, t);
         p11 = sat_add(p11, mul_rnd(bias_q, dt, 16));
         s = sat_add(p00, meas_q);
         if (s == 0) begin
            o.gain_fault = 1'b1;
         end else begin
            k0 = gain_div(p00, s);
            k1 = gain_div(p10, s);
         end
         y = sat_sub(z, angle_est);
         angle_est = sat_add(angle_est, mul_rnd(k0, y, 32));
         bias_est = sat_add(bias_est, mul_rnd(k1, y, 32));
         a00 = p00;
         a01 = p01;
         p00 = sat_sub(p00, mul_rnd(k0, a00, 32));
         p01 = sat_sub(p01, mul_rnd(k0, a01, 32));
         p10 = sat_sub(p10, mul_rnd(k1, a00, 32));
         p11 = sat_sub(p11, mul_rnd(k1, a01, 32));
      end
      o.filtered_angle = to_port(angle_est);
      o.gyro_bias = to_port(bias_est);
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      filter_out_type e;
      if (reset) begin
         angle_est = 0; bias_est = 0;
         p00 = 0; p01 = 0; p10 = 0; p11 = 0;
         angle_q = fx_type'(ANGLE_NOISE_RST);
         bias_q = fx_type'(BIAS_NOISE_RST);
         meas_q = fx_type'(MEAS_NOISE_RST);
         wrap_en = 1'b0;
         expected_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.reg_index)
               CSR_ANGLE_NOISE: angle_q = fx_type'({32'b0, csr.wdata});
               CSR_BIAS_NOISE:  bias_q = fx_type'({32'b0, csr.wdata});
               CSR_MEAS_NOISE:  meas_q = fx_type'({32'b0, csr.wdata});
               CSR_WRAP_EN:     wrap_en = csr.wdata[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word angle=%0d bias=%0d",
                           $realtime, rsp.filtered_angle, rsp.gyro_bias);
            end else begin
               e = expected_q.pop_front();
               if (rsp.filtered_angle !== e.filtered_angle || rsp.gyro_bias !== e.gyro_bias ||
                   rsp.guard_taken !== e.guard_taken || rsp.gain_fault !== e.gain_fault) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp angle=%0d bias=%0d guard=%0b fault=%0b, got angle=%0d bias=%0d guard=%0b fault=%0b",
                              $realtime, e.filtered_angle, e.gyro_bias, e.guard_taken,
                              e.gain_fault, rsp.filtered_angle, rsp.gyro_bias,
                              rsp.guard_taken, rsp.gain_fault);
               end
            end
         end
         if (req.valid && req.ready)
            expected_q.push_back(filter_update(req.measured_angle, req.angular_rate,
                                               req.time_step));
      end
   end

endmodule

@@ test/tb_top.sv @@
// Top of the angle/bias filter testbench: clock, reset, stimulus phases and verdict.
// Depends on kabf_pkg, kabf_intf, kalman_angle_bias_filter and kabf_checker.
`timescale 1ns / 1ps
module tb_top;
   import kabf_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 300;
   localparam int DEG = 65536;

   logic clock;
   logic reset;
   int   pending, mismatches;
   int   idle_cycles;
   int   burst_left;

   kabf_req_if req_ch();
   kabf_rsp_if rsp_ch();
   kabf_csr_if csr_ch();

   kalman_angle_bias_filter i_dut (
      .clock(clock), .reset(reset),
      .req_if(req_ch), .rsp_if(rsp_ch), .csr_if(csr_ch)
   );

   kabf_checker i_checker (
      .clock(clock), .reset(reset),
      .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .pending(pending), .mismatches(mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stall pattern: modes of always ready, coin flip and long stalls
   initial begin
      int mode, run;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         run = $urandom_range(5, 60);
         repeat (run) begin
            @(negedge clock);
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // one word; valid stays up across a burst, drops for the gap between bursts
   task automatic send_word(logic signed [31:0] meas, logic signed [31:0] rate,
                            logic [15:0] dt);
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.measured_angle <= meas;
      req_ch.angular_rate <= rate;
      req_ch.time_step <= dt;
      do @(posedge clock); while (!req_ch.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 20)) @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_words(int count);
      int base, dir;
      base = $urandom_range(0, 340 * DEG) - 170 * DEG;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0: send_word($urandom, $urandom, 16'($urandom));
            1: send_word(-base, $urandom_range(0, 400 * DEG) - 200 * DEG,
                         16'($urandom_range(0, 2000)));
            default: begin
               dir = $urandom_range(0, 6 * DEG) - 3 * DEG;
               base = base + dir;
               if (base > 179 * DEG || base < -179 * DEG) base = -base;
               send_word(base + $urandom_range(0, DEG) - DEG / 2,
                         $urandom_range(0, 100 * DEG) - 50 * DEG,
                         16'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 1400)));
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      burst_left = 0;
      req_ch.valid = 1'b0;
      req_ch.measured_angle = '0;
      req_ch.angular_rate = '0;
      req_ch.time_step = '0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: field extremes
      send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
      send_word(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);
      send_word(0, 0, 16'd0);
      send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001);
      send_word(-1, 1, 16'h8000);
      random_words(300);
      drain();

      // all noise zero: innovation variance stays zero, gains fault
      csr_write(CSR_ANGLE_NOISE, 32'd0);
      csr_write(CSR_BIAS_NOISE, 32'd0);
      csr_write(CSR_MEAS_NOISE, 32'd0);
      csr_write(CSR_WRAP_EN, 32'd0);
      drain();
      csr_write(8'hFF, 32'hFFFF_FFFF);  // unmapped index
      send_word(10 * DEG, 5 * DEG, 16'd0);
      send_word(-20 * DEG, 0, 16'd0);
      random_words(200);
      drain();

      // largest noise, guard on: drive estimate past +90, then jump across
      csr_write(CSR_ANGLE_NOISE, 32'hFFFF_FFFF);
      csr_write(CSR_BIAS_NOISE, 32'hFFFF_FFFF);
      csr_write(CSR_MEAS_NOISE, 32'hFFFF_FFFF);
      csr_write(CSR_WRAP_EN, 32'hFFFF_FFFF);
      repeat (8) send_word(170 * DEG, 0, 16'hFFFF);
      send_word(-170 * DEG, 0, 16'h0100);
      send_word(170 * DEG, 0, 16'h0100);
      send_word(-90 * DEG, 0, 16'h0100);
      random_words(400);
      drain();

      // defaults again with guard on
      csr_write(CSR_ANGLE_NOISE, ANGLE_NOISE_RST);
      csr_write(CSR_BIAS_NOISE, BIAS_NOISE_RST);
      csr_write(CSR_MEAS_NOISE, MEAS_NOISE_RST);
      csr_write(CSR_WRAP_EN, 32'd1);
      random_words(400);
      drain();

      // random settings
      repeat (4) begin
         csr_write(CSR_ANGLE_NOISE, $urandom);
         csr_write(CSR_BIAS_NOISE, $urandom >> $urandom_range(0, 31));
         csr_write(CSR_MEAS_NOISE, $urandom >> $urandom_range(0, 31));
         csr_write(CSR_WRAP_EN, $urandom);
         random_words(100);
         drain();
      end

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
